@@ hw/rtl/bpm_pkg.sv @@
// Shared types and constants for the boot progress bus monitor.
// Holds command, outcome and register codes, bus word patterns and the queue item.
// No dependencies.
package bpm_pkg;

   // Command codes on the request channel
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_START = 2'd0;
   localparam cmd_type CMD_WORD  = 2'd1;
   localparam cmd_type CMD_TICK  = 2'd2;

   // Outcome codes on the response channel
   typedef logic [2:0] outcome_type;
   localparam outcome_type OUT_RUNNING = 3'd0;
   localparam outcome_type OUT_SUCCESS = 3'd1;
   localparam outcome_type OUT_RETRIES = 3'd2;
   localparam outcome_type OUT_TO_READ = 3'd3;
   localparam outcome_type OUT_TO_INIT = 3'd4;
   localparam outcome_type OUT_TO_IDLE = 3'd5;

   // Configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_TOTAL_TIMEOUT = 2'd0;
   localparam csr_index_type CSR_INIT_TIMEOUT  = 2'd1;
   localparam csr_index_type CSR_READ_TIMEOUT  = 2'd2;
   localparam csr_index_type CSR_MAX_RETRIES   = 2'd3;

   localparam int TIMER_W = 16;
   localparam int RETRY_CFG_W = 3;
   localparam int RETRY_W = RETRY_CFG_W + 1;
   localparam int WORD_W = 32;

   // Register reset values
   localparam logic [TIMER_W-1:0] TOTAL_TIMEOUT_RST = 16'd1000;
   localparam logic [TIMER_W-1:0] INIT_TIMEOUT_RST  = 16'd20;
   localparam logic [TIMER_W-1:0] READ_TIMEOUT_RST  = 16'd100;
   localparam logic [RETRY_CFG_W-1:0] MAX_RETRIES_RST = 3'd4;

   // Bus word patterns
   localparam logic [WORD_W-1:0] WORD_INIT_CMD   = 32'h4100_0000;
   localparam logic [WORD_W-1:0] WORD_INIT_ARG   = 32'h0000_00F9;
   localparam logic [7:0]        WORD_REPLY_TOP  = 8'h3F;
   localparam logic [WORD_W-1:0] WORD_READ_CMD   = 32'h5100_0000;
   localparam logic [WORD_W-1:0] WORD_BLK0_ARG   = 32'h0000_0055;
   localparam logic [WORD_W-1:0] WORD_STATUS_CMD = 32'h4D00_0200;
   localparam logic [WORD_W-1:0] WORD_STATUS_ARG = 32'h0000_00B1;
   localparam logic [WORD_W-1:0] WORD_BLK1_ARG   = 32'h0000_0147;

   // Classified transaction passed from front to back
   typedef struct packed {
      cmd_type cmd;
      logic    is_init_cmd;
      logic    is_init_arg;
      logic    is_read_cmd;
      logic    is_status_cmd;
      logic    is_reply;
      logic    is_blk0_arg;
      logic    is_status_arg;
      logic    is_blk1_arg;
   } item_type;

   // Queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

@@ hw/rtl/bpm_ifs.sv @@
// Channel interfaces for the boot progress bus monitor.
// Request, response and configuration write channels; depends on bpm_pkg.
interface bpm_req_if import bpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [WORD_W-1:0]   bus_word;
   modport source (output valid, output cmd, output bus_word, input ready);
   modport sink   (input valid, input cmd, input bus_word, output ready);
endinterface

interface bpm_rsp_if ();
   logic       valid;
   logic       ready;
   logic       pulse_target_reset;
   logic [2:0] outcome;
   logic       is_done;
   logic       newer_chip;
   modport source (output valid, output pulse_target_reset, output outcome,
                   output is_done, output newer_chip, input ready);
   modport sink   (input valid, input pulse_target_reset, input outcome,
                   input is_done, input newer_chip, output ready);
endinterface

interface bpm_csr_if import bpm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         index;
   logic [TIMER_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bpm_front.sv @@
// Front end: accepts request transactions and classifies the bus word.
// Depends on bpm_pkg and bpm_req_if.
module bpm_front import bpm_pkg::*; (
   bpm_req_if.sink   req_ch,
   output logic      push_valid,
   output item_type  push_item,
   input  logic      push_ready
);

   logic [WORD_W-1:0] word;

   assign word = req_ch.bus_word;

   // Pass handshake straight to the queue
   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   // Match the word against every pattern the back end cares about
   always_comb begin
      push_item.cmd           = req_ch.cmd;
      push_item.is_init_cmd   = (word == WORD_INIT_CMD);
      push_item.is_init_arg   = (word == WORD_INIT_ARG);
      push_item.is_read_cmd   = (word == WORD_READ_CMD);
      push_item.is_status_cmd = (word == WORD_STATUS_CMD);
      push_item.is_reply      = (word[WORD_W-1 -: 8] == WORD_REPLY_TOP);
      push_item.is_blk0_arg   = (word == WORD_BLK0_ARG);
      push_item.is_status_arg = (word == WORD_STATUS_ARG);
      push_item.is_blk1_arg   = (word == WORD_BLK1_ARG);
   end

endmodule

@@ hw/rtl/bpm_queue.sv @@
// Short FIFO of classified transactions between front and back.
// Depends on bpm_pkg.
module bpm_queue import bpm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/bpm_back.sv @@
// Back end: deadline counters, bus sequence tracking, config registers and
// the response register. Depends on bpm_pkg, bpm_rsp_if and bpm_csr_if.
module bpm_back import bpm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  item_type  pop_item,
   output logic      pop_ready,
   bpm_csr_if.sink   csr_ch,
   bpm_rsp_if.source rsp_ch
);

   // Configuration registers
   logic [TIMER_W-1:0]     total_to_ff, init_to_ff, read_to_ff;
   logic [RETRY_CFG_W-1:0] max_retries_ff;

   // Monitor state
   logic                 active_ff, active_in;
   logic                 seen_b0_ff, seen_b0_in;
   logic                 seen_init_ff, seen_init_in;
   logic                 newer_ff, newer_in;
   logic                 prev_init_cmd_ff, prev_init_cmd_in;
   logic                 prev_init_arg_ff, prev_init_arg_in;
   logic                 prev_read_cmd_ff, prev_read_cmd_in;
   logic                 prev_status_cmd_ff, prev_status_cmd_in;
   logic [TIMER_W-1:0]   overall_ff, overall_in;
   logic [TIMER_W-1:0]   init_ff, init_in;
   logic [RETRY_W-1:0]   retry_ff, retry_in;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pulse_ff, rsp_pulse_in;
   outcome_type          rsp_outcome_ff, rsp_outcome_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic                 rsp_newer_ff;

   logic                 take;
   logic [TIMER_W-1:0]   overall_dec, init_dec;
   logic                 finish;

   assign pop_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign take         = pop_valid && pop_ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.pulse_target_reset = rsp_pulse_ff;
   assign rsp_ch.outcome            = rsp_outcome_ff;
   assign rsp_ch.is_done            = rsp_done_ff;
   assign rsp_ch.newer_chip         = rsp_newer_ff;

   assign overall_dec = (overall_ff == '0) ? '0 : overall_ff - 1'b1;
   assign init_dec    = (init_ff == '0) ? '0 : init_ff - 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_to_ff    <= TOTAL_TIMEOUT_RST;
         init_to_ff     <= INIT_TIMEOUT_RST;
         read_to_ff     <= READ_TIMEOUT_RST;
         max_retries_ff <= MAX_RETRIES_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_TOTAL_TIMEOUT: total_to_ff    <= csr_ch.data;
            CSR_INIT_TIMEOUT:  init_to_ff     <= csr_ch.data;
            CSR_READ_TIMEOUT:  read_to_ff     <= csr_ch.data;
            CSR_MAX_RETRIES:   max_retries_ff <= csr_ch.data[RETRY_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Apply one transaction to the monitor state
   always_comb begin
      active_in          = active_ff;
      seen_b0_in         = seen_b0_ff;
      seen_init_in       = seen_init_ff;
      newer_in           = newer_ff;
      prev_init_cmd_in   = prev_init_cmd_ff;
      prev_init_arg_in   = prev_init_arg_ff;
      prev_read_cmd_in   = prev_read_cmd_ff;
      prev_status_cmd_in = prev_status_cmd_ff;
      overall_in         = overall_ff;
      init_in            = init_ff;
      retry_in           = retry_ff;
      rsp_pulse_in       = 1'b0;
      rsp_outcome_in     = OUT_RUNNING;
      rsp_done_in        = 1'b0;
      finish             = 1'b0;

      case (pop_item.cmd)
         CMD_START: begin
            overall_in         = total_to_ff;
            init_in            = total_to_ff;
            prev_init_cmd_in   = 1'b0;
            prev_init_arg_in   = 1'b0;
            prev_read_cmd_in   = 1'b0;
            prev_status_cmd_in = 1'b0;
            seen_b0_in         = 1'b0;
            seen_init_in       = 1'b0;
            retry_in           = '0;
            active_in          = 1'b1;
            rsp_pulse_in       = 1'b1;
         end
         CMD_TICK: begin
            if (active_ff) begin
               overall_in = overall_dec;
               init_in    = init_dec;
               if (overall_dec == '0) begin
                  rsp_done_in = 1'b1;
                  active_in   = 1'b0;
                  if (seen_b0_ff) begin
                     rsp_outcome_in = OUT_TO_READ;
                  end else if (seen_init_ff) begin
                     rsp_outcome_in = OUT_TO_INIT;
                  end else begin
                     rsp_outcome_in = OUT_TO_IDLE;
                  end
               end else if (init_dec == '0) begin
                  if (retry_ff > {1'b0, max_retries_ff}) begin
                     rsp_outcome_in = OUT_RETRIES;
                     rsp_done_in    = 1'b1;
                     active_in      = 1'b0;
                  end else begin
                     retry_in     = retry_ff + 1'b1;
                     rsp_pulse_in = 1'b1;
                     init_in      = overall_dec;
                  end
               end
            end
         end
         CMD_WORD: begin
            if (active_ff) begin
               // First matching pair wins
               if (prev_init_cmd_ff && pop_item.is_init_arg) begin
                  init_in      = init_to_ff;
                  seen_init_in = 1'b1;
               end else if (prev_init_arg_ff && pop_item.is_reply) begin
                  init_in = overall_ff;
               end else if (prev_read_cmd_ff && pop_item.is_blk0_arg) begin
                  overall_in = read_to_ff;
                  seen_b0_in = 1'b1;
               end else if (seen_b0_ff && prev_status_cmd_ff && pop_item.is_status_arg) begin
                  newer_in = 1'b0;
               end else if (prev_read_cmd_ff && pop_item.is_blk1_arg) begin
                  finish = 1'b1;
               end
               if (finish) begin
                  rsp_outcome_in = OUT_SUCCESS;
                  rsp_done_in    = 1'b1;
                  active_in      = 1'b0;
               end else begin
                  prev_init_cmd_in   = pop_item.is_init_cmd;
                  prev_init_arg_in   = pop_item.is_init_arg;
                  prev_read_cmd_in   = pop_item.is_read_cmd;
                  prev_status_cmd_in = pop_item.is_status_cmd;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ch.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff          <= 1'b0;
         seen_b0_ff         <= 1'b0;
         seen_init_ff       <= 1'b0;
         newer_ff           <= 1'b1;
         prev_init_cmd_ff   <= 1'b0;
         prev_init_arg_ff   <= 1'b0;
         prev_read_cmd_ff   <= 1'b0;
         prev_status_cmd_ff <= 1'b0;
         overall_ff         <= '0;
         init_ff            <= '0;
         retry_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            active_ff          <= active_in;
            seen_b0_ff         <= seen_b0_in;
            seen_init_ff       <= seen_init_in;
            newer_ff           <= newer_in;
            prev_init_cmd_ff   <= prev_init_cmd_in;
            prev_init_arg_ff   <= prev_init_arg_in;
            prev_read_cmd_ff   <= prev_read_cmd_in;
            prev_status_cmd_ff <= prev_status_cmd_in;
            overall_ff         <= overall_in;
            init_ff            <= init_in;
            retry_ff           <= retry_in;
         end
      end
   end

   // Load response payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_pulse_ff   <= rsp_pulse_in;
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_done_ff    <= rsp_done_in;
         rsp_newer_ff   <= newer_in;
      end
   end

   // A finished run always reports a non-running outcome
   a_done_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_outcome_ff != OUT_RUNNING)
      else $error("done response with running outcome");

   // Reset request and end of monitoring never share a response
   a_pulse_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pulse_ff && rsp_done_ff))
      else $error("reset pulse on a done response");

   // Leaving the active state is reported in the response just loaded
   a_fell_done: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> rsp_valid_ff && rsp_done_ff)
      else $error("monitoring ended without a done response");

   // Retry count only grows together with a reset pulse
   a_retry_pulse: assert property (@(posedge clock) disable iff (reset)
      take && (retry_in != retry_ff) && (pop_item.cmd == CMD_TICK) |=> rsp_pulse_ff)
      else $error("retry counted without reset pulse");

endmodule

@@ hw/rtl/boot_progress_bus_monitor_core.sv @@
// Boot progress bus monitor, top level. Accepts one request transaction per
// cycle while responses are taken and returns exactly one response for each,
// loaded into the response register once its transaction leaves the queue.
// The sustained rate, one transaction per cycle, is set by the back end's
// update of the deadline counters and sequence state for each transaction.
// A two-entry queue parts the classifier from the back end. The response
// register is reloaded at the edge where the waiting response leaves; while
// a response is held, the back end stalls and the queue fills, after which
// requests stall. Configuration writes are taken on every cycle. Depends on
// bpm_pkg, the channel interfaces, bpm_front, bpm_queue and bpm_back.
module boot_progress_bus_monitor_core import bpm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bpm_req_if.sink   req_ch,
   bpm_rsp_if.source rsp_ch,
   bpm_csr_if.sink   csr_ch
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   // Classify incoming transactions
   bpm_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Decouple front from back
   bpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // Track deadlines and bus sequence, drive responses
   bpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule
